// File: src/semaphore_recursive_mutex_unit_assert.svh
// Assertion macros used by the semaphore unit's RTL.
`ifndef SEMAPHORE_RECURSIVE_MUTEX_UNIT_ASSERT_SVH
`define SEMAPHORE_RECURSIVE_MUTEX_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define SMRU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smru assertion failed");

// Next-cycle implication, off while reset is high.
`define SMRU_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smru assertion failed");

`endif

// File: src/smru_pkg.sv
package smru_pkg;

  // Result status codes
  localparam logic [1:0] ST_GRANTED  = 2'd0;
  localparam logic [1:0] ST_BLOCKED  = 2'd1;
  localparam logic [1:0] ST_RELEASED = 2'd2;
  localparam logic [1:0] ST_ERROR    = 2'd3;

  // Request kinds
  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_LOCK_MODE     = 1'b0;
  localparam logic REG_INITIAL_COUNT = 1'b1;

  localparam int TID_W   = 5;
  localparam int DEPTH_W = 8;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'd255;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic       lock_mode;
    logic [7:0] initial_count;
    logic       reinit;       // one-cycle pulse after any register write
  } cfg_t;

endpackage

// File: src/smru_ram.sv
module smru_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/smru_cfg.sv
module smru_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output smru_pkg::cfg_t      cfg
);

  logic       lock_mode;
  logic [7:0] initial_count;
  logic       reinit;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_mode     <= 1'b1;
      initial_count <= 8'd1;
      reinit        <= 1'b0;
    end else begin
      reinit <= wr_en;
      if (wr_en) begin
        unique case (paddr[2])
          smru_pkg::REG_LOCK_MODE:     lock_mode     <= pwdata[0];
          smru_pkg::REG_INITIAL_COUNT: initial_count <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      smru_pkg::REG_LOCK_MODE:     prdata = {31'b0, lock_mode};
      smru_pkg::REG_INITIAL_COUNT: prdata = {24'b0, initial_count};
      default:                     prdata = '0;
    endcase
  end

  assign cfg.lock_mode     = lock_mode;
  assign cfg.initial_count = initial_count;
  assign cfg.reinit        = reinit;

endmodule

// File: src/semaphore_recursive_mutex_unit.sv
// Channel   | Handshake                    | Payload
// ----------+------------------------------+------------------------------------------
// request   | start & !busy                | kind, thread_id
// result    | done (one-cycle strobe)      | status, woken_valid, woken_thread,
//           |                              | count_after
// config    | psel & penable & pwrite      | paddr, pwdata (prdata on read), pready=1
//
// For each request, the accept cycle issues the wait-queue head read
// to the RAM, the next cycle has the head entry and does the read-modify-write of
// all state; done pulses in the cycle after that, when busy is already low.
// A new request may be accepted in the same cycle the previous result is shown.
// Reset is synchronous, active high: mutex mode, count one, empty queue.
// A register write reloads the count, queue and holder via the reinit register;
// no clearing pass is needed since the queue RAM is only read below its fill count.
// The receiver cannot stall: each result is a single-cycle transfer.
`include "semaphore_recursive_mutex_unit_assert.svh"

module semaphore_recursive_mutex_unit #(
  parameter int THREAD_COUNT = 32,
  parameter int COUNT_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  // request
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [4:0]  thread_id,
  // result
  output logic        done,
  output logic [1:0]  status,
  output logic        woken_valid,
  output logic [4:0]  woken_thread,
  output logic [7:0]  count_after,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(THREAD_COUNT);  // queue pointer / thread index width
  localparam int FW = IW + 1;                // fill count holds THREAD_COUNT
  localparam int CW = COUNT_BITS;
  localparam int TW = smru_pkg::TID_W;
  localparam int DW = smru_pkg::DEPTH_W;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t              state;
  smru_pkg::cfg_t      cfg;

  // held request
  logic                req_kind;
  logic [TW-1:0]       req_tid;

  // semaphore and queue state
  logic [CW-1:0]           sem_count;
  logic [IW-1:0]           fifo_head;
  logic [IW-1:0]           fifo_tail;
  logic [FW-1:0]           fifo_fill;
  logic [THREAD_COUNT-1:0] waiting_map;
  logic                    holder_valid;
  logic [TW-1:0]           holder_thread;
  logic [DW-1:0]           recursion_depth;

  logic [TW-1:0]       head_data;
  logic                accept;

  // decision for the request in S_EXEC
  logic                in_range;
  logic [IW-1:0]       tid_idx;
  logic [IW-1:0]       head_idx;
  logic                is_waiting;
  logic                is_holder;
  logic                q_full;
  logic                q_nonempty;
  logic                cnt_zero;
  logic                cnt_max;
  logic [1:0]          res_status;
  logic                do_dec;
  logic                do_enq;
  logic                do_up;
  logic                take_lock;
  logic                drop_lock;
  logic                depth_inc;
  logic                depth_dec;
  logic [IW-1:0]       head_next;
  logic [IW-1:0]       tail_next;
  logic [CW-1:0]       sem_count_next;
  logic [CW-1:0]       init_count;

  smru_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Wait queue storage: read the head at accept, push at the tail in S_EXEC.
  // The interlock of one request at a time keeps the read behind any push.
  smru_ram #(
    .WIDTH (TW),
    .DEPTH (THREAD_COUNT)
  ) u_wait_ram (
    .clk   (clk),
    .we    (state == S_EXEC && do_enq),
    .waddr (fifo_tail),
    .wdata (req_tid),
    .re    (accept),
    .raddr (fifo_head),
    .rdata (head_data)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign in_range   = 32'(req_tid) < 32'(THREAD_COUNT);
  assign tid_idx    = IW'(req_tid);
  assign head_idx   = IW'(head_data);
  assign is_waiting = in_range && waiting_map[tid_idx];
  assign is_holder  = holder_valid && (holder_thread == req_tid);
  assign q_full     = (fifo_fill == FW'(THREAD_COUNT));
  assign q_nonempty = (fifo_fill != '0);
  assign cnt_zero   = (sem_count == '0);
  assign cnt_max    = &sem_count;
  assign init_count = cfg.lock_mode ? CW'(1) : CW'(cfg.initial_count);

  assign head_next = (fifo_head == IW'(THREAD_COUNT - 1)) ? '0 : fifo_head + 1'b1;
  assign tail_next = (fifo_tail == IW'(THREAD_COUNT - 1)) ? '0 : fifo_tail + 1'b1;

  // Work out one request; every error arm leaves all actions low.
  always_comb begin
    res_status = smru_pkg::ST_ERROR;
    do_dec     = 1'b0;
    do_enq     = 1'b0;
    do_up      = 1'b0;
    take_lock  = 1'b0;
    drop_lock  = 1'b0;
    depth_inc  = 1'b0;
    depth_dec  = 1'b0;
    if (!in_range || is_waiting) begin
      res_status = smru_pkg::ST_ERROR;
    end else if (!cfg.lock_mode) begin
      // counting semaphore
      if (req_kind == smru_pkg::KIND_ACQUIRE) begin
        if (!cnt_zero) begin
          do_dec     = 1'b1;
          res_status = smru_pkg::ST_GRANTED;
        end else if (!q_full) begin
          do_enq     = 1'b1;
          res_status = smru_pkg::ST_BLOCKED;
        end
      end else if (!cnt_max) begin
        do_up      = 1'b1;
        res_status = smru_pkg::ST_RELEASED;
      end
    end else begin
      // recursive mutex
      if (req_kind == smru_pkg::KIND_ACQUIRE) begin
        if (is_holder) begin
          if (recursion_depth < smru_pkg::DEPTH_MAX) begin
            depth_inc  = 1'b1;
            res_status = smru_pkg::ST_GRANTED;
          end
        end else if (!cnt_zero) begin
          do_dec     = 1'b1;
          take_lock  = 1'b1;
          res_status = smru_pkg::ST_GRANTED;
        end else if (!q_full) begin
          do_enq     = 1'b1;
          res_status = smru_pkg::ST_BLOCKED;
        end
      end else if (is_holder) begin
        if (recursion_depth <= DW'(1)) begin
          if (!cnt_max) begin
            drop_lock  = 1'b1;
            do_up      = 1'b1;
            res_status = smru_pkg::ST_RELEASED;
          end
        end else begin
          depth_dec  = 1'b1;
          res_status = smru_pkg::ST_RELEASED;
        end
      end
    end
  end

  always_comb begin
    sem_count_next = sem_count;
    if (do_dec) begin
      sem_count_next = sem_count - 1'b1;
    end else if (do_up) begin
      sem_count_next = sem_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      done            <= 1'b0;
      sem_count       <= CW'(1);
      fifo_head       <= '0;
      fifo_tail       <= '0;
      fifo_fill       <= '0;
      waiting_map     <= '0;
      holder_valid    <= 1'b0;
      holder_thread   <= '0;
      recursion_depth <= '0;
    end else begin
      done <= 1'b0;
      if (cfg.reinit) begin
        // reload from the freshly written registers
        sem_count       <= init_count;
        fifo_head       <= '0;
        fifo_tail       <= '0;
        fifo_fill       <= '0;
        waiting_map     <= '0;
        holder_valid    <= 1'b0;
        holder_thread   <= '0;
        recursion_depth <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_kind <= kind;
            req_tid  <= thread_id;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          state        <= S_IDLE;
          done         <= 1'b1;
          status       <= res_status;
          woken_valid  <= do_up && q_nonempty;
          woken_thread <= (do_up && q_nonempty) ? head_data : '0;
          count_after  <= 8'(sem_count_next);
          sem_count    <= sem_count_next;
          if (do_enq) begin
            // push at the tail and mark the thread as waiting
            fifo_tail            <= tail_next;
            fifo_fill            <= fifo_fill + 1'b1;
            waiting_map[tid_idx] <= 1'b1;
          end
          if (do_up && q_nonempty) begin
            // pop the oldest waiter; it must acquire again
            fifo_head             <= head_next;
            fifo_fill             <= fifo_fill - 1'b1;
            waiting_map[head_idx] <= 1'b0;
          end
          if (take_lock) begin
            holder_valid    <= 1'b1;
            holder_thread   <= req_tid;
            recursion_depth <= DW'(1);
          end else if (drop_lock) begin
            holder_valid    <= 1'b0;
            holder_thread   <= '0;
            recursion_depth <= '0;
          end else if (depth_inc) begin
            recursion_depth <= recursion_depth + 1'b1;
          end else if (depth_dec) begin
            recursion_depth <= recursion_depth - 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result follows request work in S_EXEC, which comes straight after accept.
  `SMRU_ASSERT_NXT(a_accept_to_done, clk, rst, accept, done == 1'b0 && state == S_EXEC)
  `SMRU_ASSERT_NXT(a_exec_to_done, clk, rst, state == S_EXEC, done && state == S_IDLE)
  // Each queued thread has exactly one waiting mark.
  `SMRU_ASSERT_IMP(a_map_matches_fill, clk, rst, 1'b1,
                   $countones(waiting_map) == 32'(fifo_fill))
  // In mutex mode the binary count is zero exactly while someone holds the lock.
  `SMRU_ASSERT_IMP(a_holder_vs_count, clk, rst, cfg.lock_mode && !cfg.reinit,
                   holder_valid == (sem_count == '0))
  // A woken thread is only reported by a successful release.
  `SMRU_ASSERT_IMP(a_woken_on_release, clk, rst, done && woken_valid,
                   status == smru_pkg::ST_RELEASED)

endmodule

// File: tb/semaphore_recursive_mutex_unit_tb.sv
module semaphore_recursive_mutex_unit_tb;
  import smru_pkg::*;

  localparam int THREAD_COUNT = 32;
  localparam logic [7:0] COUNT_MAX = 8'hFF;
  // Cycles with no transfer at all before the run is called hung; the slowest
  // correct stretch is a register write after a drain.
  localparam int STALL_LIMIT = 500;
  // Give the last result room to come back at the end.
  localparam int DRAIN_CYCLES = 8;
  // Item window with no sender gaps at all.
  localparam int QUIET_FROM = 600;
  localparam int QUIET_TO   = 900;

  typedef struct packed {
    logic [1:0] status;
    logic       woken_valid;
    logic [4:0] woken_thread;
    logic [7:0] count_after;
  } result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_op_e;

  typedef struct packed {
    row_op_e    op;
    logic       req_kind;
    logic [4:0] tid;
    logic       reg_sel;
    logic [7:0] reg_val;
    logic       typed;      // take want as is instead of the lock model
    result_t    want;
  } row_t;

  typedef struct {
    logic       mutex;
    logic [7:0] init;
    int         items;
    bit         deep_burst;
  } phase_t;

  localparam result_t ANY = '0;
  localparam int N_ROWS = 26;

  // Directed opener. Starts in the reset setting (mutex, count one), then
  // moves to counting mode at both count extremes.
  row_t dir_rows [N_ROWS] = '{
    // first lock by thread 0 takes the only unit
    '{ROW_REQ, KIND_ACQUIRE, 5'd0,  1'b0, 8'd0, 1'b1, '{ST_GRANTED, 1'b0, 5'd0, 8'd0}},
    // holder re-locks: depth only
    '{ROW_REQ, KIND_ACQUIRE, 5'd0,  1'b0, 8'd0, 1'b0, ANY},
    // unlock by a thread that does not hold the lock
    '{ROW_REQ, KIND_RELEASE, 5'd31, 1'b0, 8'd0, 1'b1, '{ST_ERROR, 1'b0, 5'd0, 8'd0}},
    '{ROW_REQ, KIND_ACQUIRE, 5'd31, 1'b0, 8'd0, 1'b1, '{ST_BLOCKED, 1'b0, 5'd0, 8'd0}},
    // a queued thread may not present anything
    '{ROW_REQ, KIND_ACQUIRE, 5'd31, 1'b0, 8'd0, 1'b1, '{ST_ERROR, 1'b0, 5'd0, 8'd0}},
    '{ROW_REQ, KIND_RELEASE, 5'd31, 1'b0, 8'd0, 1'b1, '{ST_ERROR, 1'b0, 5'd0, 8'd0}},
    '{ROW_REQ, KIND_ACQUIRE, 5'd10, 1'b0, 8'd0, 1'b0, ANY},
    '{ROW_REQ, KIND_RELEASE, 5'd0,  1'b0, 8'd0, 1'b0, ANY},
    // last unlock hands the unit back and wakes the oldest waiter
    '{ROW_REQ, KIND_RELEASE, 5'd0,  1'b0, 8'd0, 1'b1, '{ST_RELEASED, 1'b1, 5'd31, 8'd1}},
    // unlock with no holder
    '{ROW_REQ, KIND_RELEASE, 5'd0,  1'b0, 8'd0, 1'b1, '{ST_ERROR, 1'b0, 5'd0, 8'd1}},
    '{ROW_REQ, KIND_ACQUIRE, 5'd10, 1'b0, 8'd0, 1'b0, ANY},
    // woken thread presents its lock again
    '{ROW_REQ, KIND_ACQUIRE, 5'd31, 1'b0, 8'd0, 1'b0, ANY},
    '{ROW_REQ, KIND_RELEASE, 5'd31, 1'b0, 8'd0, 1'b0, ANY},
    '{ROW_REQ, KIND_ACQUIRE, 5'd10, 1'b0, 8'd0, 1'b0, ANY},
    '{ROW_REQ, KIND_RELEASE, 5'd10, 1'b0, 8'd0, 1'b0, ANY},
    '{ROW_CFG, KIND_ACQUIRE, 5'd0,  REG_LOCK_MODE,     8'd0,   1'b0, ANY},
    '{ROW_CFG, KIND_ACQUIRE, 5'd0,  REG_INITIAL_COUNT, 8'd255, 1'b0, ANY},
    // count already at its top
    '{ROW_REQ, KIND_RELEASE, 5'd1,  1'b0, 8'd0, 1'b1, '{ST_ERROR, 1'b0, 5'd0, 8'd255}},
    '{ROW_REQ, KIND_ACQUIRE, 5'd1,  1'b0, 8'd0, 1'b1, '{ST_GRANTED, 1'b0, 5'd0, 8'd254}},
    '{ROW_REQ, KIND_RELEASE, 5'd1,  1'b0, 8'd0, 1'b0, ANY},
    '{ROW_CFG, KIND_ACQUIRE, 5'd0,  REG_INITIAL_COUNT, 8'd0,   1'b0, ANY},
    '{ROW_REQ, KIND_ACQUIRE, 5'd2,  1'b0, 8'd0, 1'b1, '{ST_BLOCKED, 1'b0, 5'd0, 8'd0}},
    '{ROW_REQ, KIND_ACQUIRE, 5'd3,  1'b0, 8'd0, 1'b0, ANY},
    // in counting mode any thread may post
    '{ROW_REQ, KIND_RELEASE, 5'd4,  1'b0, 8'd0, 1'b0, ANY},
    '{ROW_REQ, KIND_ACQUIRE, 5'd4,  1'b0, 8'd0, 1'b0, ANY},
    '{ROW_REQ, KIND_RELEASE, 5'd2,  1'b0, 8'd0, 1'b0, ANY}
  };

  // Random phases; every register value extreme shows up at least once.
  phase_t phases [6] = '{
    '{1'b0, 8'd2,   250, 1'b0},
    '{1'b1, 8'd255, 200, 1'b1},
    '{1'b0, 8'd0,   200, 1'b0},
    '{1'b0, 8'd255, 150, 1'b0},
    '{1'b1, 8'd0,   150, 1'b0},
    '{1'b0, 8'd1,   130, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        kind = 1'b0;
  logic [4:0]  thread_id = 5'd0;
  logic        done;
  logic [1:0]  status;
  logic        woken_valid;
  logic [4:0]  woken_thread;
  logic [7:0]  count_after;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Lock model: configuration and state as the block should hold them.
  logic        cfg_mutex = 1'b1;
  logic [7:0]  cfg_init_count = 8'd1;
  logic [7:0]  sem_level;
  logic [4:0]  waiter_q [$];
  logic [31:0] waiter_mask;
  logic        owner_valid;
  logic [4:0]  owner_id;
  logic [7:0]  lock_depth;

  result_t     pending_results [$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          stall_cycles = 0;

  semaphore_recursive_mutex_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .thread_id    (thread_id),
    .done         (done),
    .status       (status),
    .woken_valid  (woken_valid),
    .woken_thread (woken_thread),
    .count_after  (count_after),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Clear the lock model to what the current configuration implies.
  function automatic void reset_model();
    sem_level   = cfg_mutex ? 8'd1 : cfg_init_count;
    waiter_q.delete();
    waiter_mask = '0;
    owner_valid = 1'b0;
    owner_id    = '0;
    lock_depth  = '0;
  endfunction

  function automatic logic [1:0] park_waiter(logic [4:0] tid);
    if (waiter_q.size() >= THREAD_COUNT) return ST_ERROR;
    waiter_q.push_back(tid);
    waiter_mask[tid] = 1'b1;
    return ST_BLOCKED;
  endfunction

  // Post one unit; pop the oldest waiter if there is one.
  function automatic void post_unit(ref result_t r);
    logic [4:0] head;
    if (waiter_q.size() > 0) begin
      head = waiter_q.pop_front();
      waiter_mask[head] = 1'b0;
      r.woken_valid  = 1'b1;
      r.woken_thread = head;
    end
    sem_level = sem_level + 8'd1;
  endfunction

  // Advance the lock model by one request and return the result it owes.
  function automatic result_t predict_request(logic k, logic [4:0] tid);
    result_t r;
    r = '{ST_ERROR, 1'b0, 5'd0, 8'd0};
    if (waiter_mask[tid]) begin
      r.status = ST_ERROR;
    end else if (!cfg_mutex) begin
      if (k == KIND_ACQUIRE) begin
        if (sem_level != 8'd0) begin
          sem_level = sem_level - 8'd1;
          r.status  = ST_GRANTED;
        end else begin
          r.status = park_waiter(tid);
        end
      end else if (sem_level != COUNT_MAX) begin
        post_unit(r);
        r.status = ST_RELEASED;
      end
    end else if (k == KIND_ACQUIRE) begin
      if (owner_valid && owner_id == tid) begin
        if (lock_depth < DEPTH_MAX) begin
          lock_depth = lock_depth + 8'd1;
          r.status   = ST_GRANTED;
        end
      end else if (sem_level != 8'd0) begin
        sem_level   = sem_level - 8'd1;
        owner_valid = 1'b1;
        owner_id    = tid;
        lock_depth  = 8'd1;
        r.status    = ST_GRANTED;
      end else begin
        r.status = park_waiter(tid);
      end
    end else if (owner_valid && owner_id == tid) begin
      if (lock_depth <= 8'd1) begin
        if (sem_level != COUNT_MAX) begin
          owner_valid = 1'b0;
          owner_id    = '0;
          lock_depth  = '0;
          post_unit(r);
          r.status = ST_RELEASED;
        end
      end else begin
        lock_depth = lock_depth - 8'd1;
        r.status   = ST_RELEASED;
      end
    end
    r.count_after = sem_level;
    return r;
  endfunction

  // Pick a thread that is not queued, if a few tries find one.
  function automatic logic [4:0] free_thread();
    logic [4:0] t;
    t = 5'($urandom_range(THREAD_COUNT - 1));
    for (int i = 0; i < 8 && waiter_mask[t]; i++) t = 5'($urandom_range(THREAD_COUNT - 1));
    return t;
  endfunction

  task automatic log_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Present one request and hold it until the transfer; record its result.
  // Drop start for a short random gap now and then, except in the quiet window.
  task automatic issue_request(input logic k, input logic [4:0] tid, input bit typed,
                               input result_t want);
    result_t modeled;
    start     <= 1'b1;
    kind      <= k;
    thread_id <= tid;
    do @(posedge clk); while (busy);
    modeled = predict_request(k, tid);
    pending_results.push_back(typed ? want : modeled);
    items_sent++;
    if ((items_sent < QUIET_FROM || items_sent >= QUIET_TO) && $urandom_range(99) < 19) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // Stop issuing and wait for every owed result to come back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write on an idle block: setup, then access until pready.
  task automatic reg_write(input logic sel, input logic [7:0] val);
    drain_results();
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_LOCK_MODE) cfg_mutex = val[0];
    else cfg_init_count = val;
    reset_model();
    // let the reinit pulse land before the next request
    repeat (3) @(posedge clk);
  endtask

  // Free the mutex, lock it two past the depth limit, then unlock one step
  // past zero: hits depth overflow and unlock without a holder.
  task automatic deep_lock_burst();
    logic [4:0] t;
    while (owner_valid) issue_request(KIND_RELEASE, owner_id, 1'b0, ANY);
    t = free_thread();
    while (waiter_mask[t]) t = free_thread();
    repeat (int'(DEPTH_MAX) + 2) issue_request(KIND_ACQUIRE, t, 1'b0, ANY);
    repeat (int'(DEPTH_MAX) + 1) issue_request(KIND_RELEASE, t, 1'b0, ANY);
  endtask

  // Result checker: every strobe is one transfer, matched against the oldest
  // pending expectation field by field.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        log_mismatch("result with nothing pending", int'(status), -1);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          log_mismatch("status", int'(status), int'(want.status));
        if (woken_valid !== want.woken_valid)
          log_mismatch("woken_valid", int'(woken_valid), int'(want.woken_valid));
        if (woken_thread !== want.woken_thread)
          log_mismatch("woken_thread", int'(woken_thread), int'(want.woken_thread));
        if (count_after !== want.count_after)
          log_mismatch("count_after", int'(count_after), int'(want.count_after));
      end
    end
  end

  // Watchdog: count cycles without any transfer on any port.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic       k;
    logic [4:0] t;
    int         r;
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    for (int i = 0; i < N_ROWS; i++) begin
      if (dir_rows[i].op == ROW_CFG)
        reg_write(dir_rows[i].reg_sel, dir_rows[i].reg_val);
      else
        issue_request(dir_rows[i].req_kind, dir_rows[i].tid, dir_rows[i].typed,
                      dir_rows[i].want);
    end

    // Random phases. Mostly well-formed traffic from threads that are not
    // queued; a small share is noise from any thread with any kind.
    foreach (phases[p]) begin
      reg_write(REG_LOCK_MODE, {7'd0, phases[p].mutex});
      reg_write(REG_INITIAL_COUNT, phases[p].init);
      if (phases[p].deep_burst) deep_lock_burst();
      for (int i = 0; i < phases[p].items; i++) begin
        r = $urandom_range(99);
        if (r < 8) begin
          k = 1'($urandom_range(1));
          t = 5'($urandom_range(THREAD_COUNT - 1));
        end else if (!cfg_mutex) begin
          k = 1'($urandom_range(1));
          t = free_thread();
        end else if (owner_valid && r < 45) begin
          k = KIND_ACQUIRE;
          t = owner_id;
        end else if (owner_valid && r < 80) begin
          k = KIND_RELEASE;
          t = owner_id;
        end else begin
          k = KIND_ACQUIRE;
          t = free_thread();
        end
        issue_request(k, t, 1'b0, ANY);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/smru_pkg.sv
src/smru_ram.sv
src/smru_cfg.sv
src/semaphore_recursive_mutex_unit.sv
tb/semaphore_recursive_mutex_unit_tb.sv
